/* hdl/atl_pkg.sv */
// Shared types, codes and character helpers for the assembly token lexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package atl_pkg;

   localparam int POS_BITS  = 20;
   localparam int LINE_BITS = 16;
   localparam int LEN_BITS  = 16;

   localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
   localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;

   // token kinds
   localparam logic [4:0] K_IDENT   = 5'd0;
   localparam logic [4:0] K_INT     = 5'd1;
   localparam logic [4:0] K_DIR     = 5'd2;
   localparam logic [4:0] K_CHAR    = 5'd3;
   localparam logic [4:0] K_SBYTE   = 5'd4;
   localparam logic [4:0] K_SEND    = 5'd5;
   localparam logic [4:0] K_PLUS    = 5'd6;
   localparam logic [4:0] K_MINUS   = 5'd7;
   localparam logic [4:0] K_STAR    = 5'd8;
   localparam logic [4:0] K_SLASH   = 5'd9;
   localparam logic [4:0] K_COMMA   = 5'd10;
   localparam logic [4:0] K_DOT     = 5'd11;
   localparam logic [4:0] K_COLON   = 5'd12;
   localparam logic [4:0] K_DOLLAR  = 5'd13;
   localparam logic [4:0] K_LPAREN  = 5'd14;
   localparam logic [4:0] K_RPAREN  = 5'd15;
   localparam logic [4:0] K_UNKNOWN = 5'd16;
   localparam logic [4:0] K_EOF     = 5'd17;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_X  = 8'h78;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_DOTPEND, M_DIRECTIVE, M_COMMENT,
      M_CH_OPEN, M_CH_ESC, M_CH_HEX1, M_CH_HEX2, M_CH_HEXSKIP, M_CH_CLOSE,
      M_STR, M_STR_ESC
   } lex_mode_type;

   typedef struct packed {
      logic       command;
      logic [7:0] source_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]           token_kind;
      logic [7:0]           value;
      logic [LINE_BITS-1:0] line;
      logic [POS_BITS-1:0]  start_pos;
      logic [LEN_BITS-1:0]  length;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      lex_mode_type         lex_mode;
      logic [LINE_BITS-1:0] line_count;
      logic [POS_BITS-1:0]  byte_pos;
      logic [POS_BITS-1:0]  token_start;
      logic [LEN_BITS-1:0]  token_len;
      logic [7:0]           char_accum;
   } lex_state_type;

   localparam lex_state_type STATE_RESET = '{
      lex_mode:    M_IDLE,
      line_count:  LINE_BITS'(1),
      byte_pos:    '0,
      token_start: '0,
      token_len:   '0,
      char_accum:  '0
   };

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      if (is_digit(b)) begin
         d = b - 8'h30;
         return {1'b1, d[3:0]};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = b - 8'h57;
         return {1'b1, d[3:0]};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = b - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] esc_map(input logic [7:0] b);
      case (b)
         CH_LOW_T: return CH_TAB;
         CH_LOW_N: return CH_LF;
         CH_LOW_R: return CH_CR;
         default:  return b;
      endcase
   endfunction

endpackage

`default_nettype wire

/* hdl/atl_lex_core.sv */
// Next-state and result logic of the lexer for one transfer.
// Depends on atl_pkg.
`default_nettype none

module atl_lex_core (
   input  atl_pkg::lex_state_type st,
   input  atl_pkg::req_type       req,
   output atl_pkg::lex_state_type nx,
   output logic [1:0]             rec_cnt,
   output atl_pkg::rsp_type       rec0,
   output atl_pkg::rsp_type       rec1
);
   import atl_pkg::*;

   function automatic rsp_type mk_rec(input logic [4:0] kind, input logic [7:0] val,
                                      input logic [LINE_BITS-1:0] ln,
                                      input logic [POS_BITS-1:0] pos,
                                      input logic [LEN_BITS-1:0] len);
      rsp_type r;
      r.token_kind = kind;
      r.value      = val;
      r.line       = ln;
      r.start_pos  = pos;
      r.length     = len;
      r.last       = 1'b0;
      return r;
   endfunction

   logic [7:0]          b;
   logic [LEN_BITS-1:0] len_up;
   logic [4:0]          hv;

   // dispatch of a byte from the between-tokens position
   lex_mode_type d_mode;
   logic         d_begin;
   logic         d_line_inc;
   logic         d_punct;
   logic [4:0]   d_kind;

   logic    do_disp;
   logic    a_vld, b_vld;
   rsp_type a_rec, b_rec;

   assign b      = req.source_byte;
   assign len_up = (st.token_len == LEN_MAX) ? st.token_len : st.token_len + 1'b1;
   assign hv     = hex_val(b);

   always_comb begin
      d_mode     = M_IDLE;
      d_begin    = 1'b0;
      d_line_inc = 1'b0;
      d_punct    = 1'b0;
      d_kind     = K_UNKNOWN;
      if (is_space(b)) begin
         d_line_inc = (b == CH_LF);
      end else if (b == CH_UNDER || is_alpha(b)) begin
         d_mode  = M_IDENT;
         d_begin = 1'b1;
      end else if (is_digit(b)) begin
         d_mode  = M_INT;
         d_begin = 1'b1;
      end else if (b == CH_HASH) begin
         d_mode = M_COMMENT;
      end else if (b == CH_DOT) begin
         d_mode  = M_DOTPEND;
         d_begin = 1'b1;
      end else if (b == CH_QUOTE) begin
         d_mode  = M_CH_OPEN;
         d_begin = 1'b1;
      end else if (b == CH_DQUOTE) begin
         d_mode  = M_STR;
         d_begin = 1'b1;
      end else begin
         d_punct = 1'b1;
         case (b)
            CH_PLUS:   d_kind = K_PLUS;
            CH_MINUS:  d_kind = K_MINUS;
            CH_STAR:   d_kind = K_STAR;
            CH_SLASH:  d_kind = K_SLASH;
            CH_COMMA:  d_kind = K_COMMA;
            CH_COLON:  d_kind = K_COLON;
            CH_DOLLAR: d_kind = K_DOLLAR;
            CH_LPAREN: d_kind = K_LPAREN;
            CH_RPAREN: d_kind = K_RPAREN;
            default:   d_kind = K_UNKNOWN;
         endcase
      end
   end

   always_comb begin
      nx      = st;
      do_disp = 1'b0;
      a_vld   = 1'b0;
      b_vld   = 1'b0;
      a_rec   = mk_rec(K_EOF, 8'h00, '0, st.byte_pos, '0);
      b_rec   = mk_rec(K_EOF, 8'h00, '0, st.byte_pos, '0);

      if (req.command == CMD_END || b == CH_NUL) begin
         // flush the open token, then EOF, then back to reset state
         a_vld = 1'b1;
         case (st.lex_mode)
            M_IDENT:     a_rec.token_kind = K_IDENT;
            M_INT:       a_rec.token_kind = K_INT;
            M_DIRECTIVE: a_rec.token_kind = K_DIR;
            M_DOTPEND:   a_rec.token_kind = K_DOT;
            M_CH_OPEN, M_CH_ESC, M_CH_HEX1, M_CH_HEX2, M_CH_HEXSKIP, M_CH_CLOSE: begin
               a_rec.token_kind = K_CHAR;
               a_rec.value      = st.char_accum;
            end
            M_STR, M_STR_ESC: a_rec.token_kind = K_SEND;
            default: a_vld = 1'b0;
         endcase
         a_rec.line      = st.line_count;
         a_rec.start_pos = st.token_start;
         a_rec.length    = st.token_len;
         b_vld = 1'b1;
         nx    = STATE_RESET;
      end else begin
         case (st.lex_mode)
            M_IDENT, M_DIRECTIVE: begin
               if (b == CH_UNDER || is_alpha(b) || is_digit(b)) begin
                  nx.token_len = len_up;
               end else begin
                  a_vld   = 1'b1;
                  a_rec   = mk_rec((st.lex_mode == M_IDENT) ? K_IDENT : K_DIR, 8'h00,
                                   st.line_count, st.token_start, st.token_len);
                  do_disp = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(b)) begin
                  nx.token_len = len_up;
               end else begin
                  a_vld   = 1'b1;
                  a_rec   = mk_rec(K_INT, 8'h00, st.line_count, st.token_start,
                                   st.token_len);
                  do_disp = 1'b1;
               end
            end
            M_DOTPEND: begin
               if (is_alpha(b)) begin
                  nx.lex_mode  = M_DIRECTIVE;
                  nx.token_len = len_up;
               end else begin
                  a_vld   = 1'b1;
                  a_rec   = mk_rec(K_DOT, 8'h00, st.line_count, st.token_start,
                                   st.token_len);
                  do_disp = 1'b1;
               end
            end
            M_COMMENT: begin
               do_disp = (b == CH_LF || b == CH_CR);
            end
            M_CH_OPEN: begin
               nx.token_len = len_up;
               if (b == CH_QUOTE) begin
                  a_vld       = 1'b1;
                  a_rec       = mk_rec(K_CHAR, 8'h00, st.line_count, st.token_start,
                                       len_up);
                  nx.lex_mode = M_IDLE;
               end else if (b == CH_BSLASH) begin
                  nx.lex_mode = M_CH_ESC;
               end else begin
                  nx.char_accum = b;
                  nx.lex_mode   = M_CH_CLOSE;
               end
            end
            M_CH_ESC: begin
               nx.token_len = len_up;
               if (b == CH_LOW_X) begin
                  nx.lex_mode = M_CH_HEX1;
               end else begin
                  nx.char_accum = esc_map(b);
                  nx.lex_mode   = M_CH_CLOSE;
               end
            end
            M_CH_HEX1: begin
               nx.token_len = len_up;
               if (hv[4]) begin
                  nx.char_accum = {4'h0, hv[3:0]};
                  nx.lex_mode   = M_CH_HEX2;
               end else begin
                  nx.lex_mode = M_CH_HEXSKIP;
               end
            end
            M_CH_HEX2: begin
               nx.token_len = len_up;
               if (hv[4]) begin
                  nx.char_accum = {st.char_accum[3:0], hv[3:0]};
               end
               nx.lex_mode = M_CH_CLOSE;
            end
            M_CH_HEXSKIP: begin
               nx.token_len = len_up;
               nx.lex_mode  = M_CH_CLOSE;
            end
            M_CH_CLOSE: begin
               nx.token_len = len_up;
               a_vld        = 1'b1;
               a_rec        = mk_rec(K_CHAR, st.char_accum, st.line_count, st.token_start,
                                     len_up);
               nx.lex_mode  = M_IDLE;
            end
            M_STR: begin
               nx.token_len = len_up;
               if (b == CH_DQUOTE) begin
                  a_vld       = 1'b1;
                  a_rec       = mk_rec(K_SEND, 8'h00, st.line_count, st.token_start,
                                       len_up);
                  nx.lex_mode = M_IDLE;
               end else if (b == CH_BSLASH) begin
                  nx.lex_mode = M_STR_ESC;
               end else begin
                  b_vld = 1'b1;
                  b_rec = mk_rec(K_SBYTE, b, st.line_count, st.byte_pos, LEN_BITS'(1));
               end
            end
            M_STR_ESC: begin
               nx.token_len = len_up;
               b_vld        = 1'b1;
               // escaped byte is reported at its backslash
               b_rec        = mk_rec(K_SBYTE, esc_map(b), st.line_count,
                                     (st.byte_pos != '0) ? st.byte_pos - 1'b1 : '0,
                                     LEN_BITS'(2));
               nx.lex_mode  = M_STR;
            end
            default: do_disp = 1'b1;
         endcase

         if (do_disp) begin
            nx.lex_mode = d_mode;
            if (d_begin) begin
               nx.token_start = st.byte_pos;
               nx.token_len   = LEN_BITS'(1);
               nx.char_accum  = 8'h00;
            end
            if (d_line_inc && st.line_count != LINE_MAX) begin
               nx.line_count = st.line_count + 1'b1;
            end
            if (d_punct) begin
               b_vld = 1'b1;
               b_rec = mk_rec(d_kind, 8'h00, st.line_count, st.byte_pos, LEN_BITS'(1));
            end
         end

         if (st.byte_pos != POS_MAX) begin
            nx.byte_pos = st.byte_pos + 1'b1;
         end
      end
   end

   // pack the results, token first, and mark the final one
   always_comb begin
      rec0    = a_vld ? a_rec : b_rec;
      rec1    = b_rec;
      rec_cnt = {1'b0, a_vld} + {1'b0, b_vld};
      rec0.last = (rec_cnt == 2'd1);
      rec1.last = 1'b1;
   end

endmodule

`default_nettype wire

/* hdl/atl_rsp_fifo.sv */
// Four-entry result queue: takes up to two records per cycle, hands out one.
// Depends on atl_pkg.
`default_nettype none

module atl_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  atl_pkg::rsp_type push0,
   input  atl_pkg::rsp_type push1,
   output logic             room_two,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output atl_pkg::rsp_type rsp_data
);
   import atl_pkg::*;

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_ptr_nx;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= 3'd2);
   assign wr_ptr_nx = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_cnt} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push1;
      end
   end

endmodule

`default_nettype wire

/* hdl/assembly_token_lexer.sv */
// Top level of the streaming assembler lexer: input register, lexer state, result queue.
// Depends on atl_pkg, atl_lex_core and atl_rsp_fifo.
`default_nettype none

//  channel | ports                        | transfer carries
//  --------+------------------------------+--------------------------------------
//  input   | req_valid req_ready req_data | command, source_byte
//  result  | rsp_valid rsp_ready rsp_data | token_kind value line start_pos length last
//
//  A transfer lands in the input register and is lexed there in one pass once the queue
//  has room for two results; the lexer state updates and its zero to two results go into
//  a four-entry queue. One byte per cycle is sustained while the queue has that room.
//  The input stalls only while the queue cannot take two more results.
//  Synchronous reset clears the lexer state (line 1, offset 0) and empties the queue.
module assembly_token_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  atl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output atl_pkg::rsp_type rsp_data
);
   import atl_pkg::*;

   logic          in_valid_ff, in_valid_in;
   req_type       in_item_ff;
   lex_state_type state_ff, state_in;
   lex_state_type state_nx;
   logic          room_two;
   logic          step;
   logic [1:0]    rec_cnt;
   logic [1:0]    push_cnt;
   rsp_type       rec0, rec1;

   assign step      = in_valid_ff && room_two;
   assign req_ready = !in_valid_ff || step;
   assign push_cnt  = step ? rec_cnt : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      state_in = step ? state_nx : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   atl_lex_core u_core (
      .st      (state_ff),
      .req     (in_item_ff),
      .nx      (state_nx),
      .rec_cnt (rec_cnt),
      .rec0    (rec0),
      .rec1    (rec1)
   );

   atl_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (rec0),
      .push1     (rec1),
      .room_two  (room_two),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
